// ----- hdl/lcdfs_pkg.sv -----
package lcdfs_pkg;

  localparam logic [7:0] PKT_LEAD = 8'h80;

  typedef enum logic [2:0] {
    FN_SET_PIXEL  = 3'd0,
    FN_WRITE_BYTE = 3'd1,
    FN_FILL       = 3'd2,
    FN_START      = 3'd3,
    FN_NEXT_LINE  = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    OS_MODE, OS_LINE, OS_DATA, OS_ZERO, OS_ZERO_LAST
  } out_sel_t;

  typedef enum logic [2:0] {
    M_NONE, M_RD_PIX, M_WR_PIX, M_WR_BYTE, M_WR_FILL, M_RD_LINE
  } mem_op_t;

  typedef enum logic [1:0] {
    A_HOLD, A_LINE_BASE, A_INC
  } addr_op_t;

  typedef enum logic [1:0] {
    L_HOLD, L_START, L_ADV, L_KILL
  } line_op_t;

  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_DISPATCH, C_MORE_FILL, C_MORE_BYTES, C_NO_LINE
  } cond_t;

  typedef logic [3:0] upc_t;

  localparam upc_t U_IDLE      = 4'd0;
  localparam upc_t U_PIX_RD    = 4'd1;
  localparam upc_t U_PIX_WR    = 4'd2;
  localparam upc_t U_WRB       = 4'd3;
  localparam upc_t U_FILL      = 4'd4;
  localparam upc_t U_DONE      = 4'd5;
  localparam upc_t U_START     = 4'd6;
  localparam upc_t U_NEXT      = 4'd7;
  localparam upc_t U_SEND_MODE = 4'd8;
  localparam upc_t U_SEND_LINE = 4'd9;
  localparam upc_t U_RD        = 4'd10;
  localparam upc_t U_EMIT      = 4'd11;
  localparam upc_t U_Z0        = 4'd12;
  localparam upc_t U_Z1        = 4'd13;
  localparam upc_t U_KILL      = 4'd14;

  typedef struct packed {
    logic     take;
    logic     emit;
    out_sel_t osel;
    mem_op_t  mem;
    addr_op_t aop;
    line_op_t lop;
    cond_t    cond;
    upc_t     target;
  } ctrl_word_t;

  typedef struct packed {
    logic more_fill;
    logic more_bytes;
    logic no_line;
  } flags_t;

  function automatic ctrl_word_t cw(input logic take, input logic emit, input out_sel_t osel,
                                    input mem_op_t mem, input addr_op_t aop,
                                    input line_op_t lop, input cond_t cond,
                                    input upc_t target);
    ctrl_word_t w;
    w.take   = take;
    w.emit   = emit;
    w.osel   = osel;
    w.mem    = mem;
    w.aop    = aop;
    w.lop    = lop;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // Microcode ROM: dispatch goes by in_func, a true cond to target, else fall through.
  function automatic ctrl_word_t ucode(input upc_t pc);
    ctrl_word_t w;
    unique case (pc)
      U_IDLE:      w = cw(1'b1, 1'b0, OS_ZERO, M_NONE, A_HOLD, L_HOLD, C_DISPATCH, U_IDLE);
      U_PIX_RD:    w = cw(1'b0, 1'b0, OS_ZERO, M_RD_PIX, A_HOLD, L_HOLD, C_NEVER, U_IDLE);
      U_PIX_WR:    w = cw(1'b0, 1'b0, OS_ZERO, M_WR_PIX, A_HOLD, L_HOLD, C_ALWAYS, U_IDLE);
      U_WRB:       w = cw(1'b0, 1'b0, OS_ZERO, M_WR_BYTE, A_HOLD, L_HOLD, C_ALWAYS, U_IDLE);
      U_FILL:      w = cw(1'b0, 1'b0, OS_ZERO, M_WR_FILL, A_INC, L_HOLD, C_MORE_FILL, U_FILL);
      U_DONE:      w = cw(1'b0, 1'b0, OS_ZERO, M_NONE, A_HOLD, L_HOLD, C_ALWAYS, U_IDLE);
      U_START:     w = cw(1'b0, 1'b0, OS_ZERO, M_NONE, A_HOLD, L_START, C_ALWAYS, U_SEND_MODE);
      U_NEXT:      w = cw(1'b0, 1'b0, OS_ZERO, M_NONE, A_HOLD, L_HOLD, C_NO_LINE, U_KILL);
      U_SEND_MODE: w = cw(1'b0, 1'b1, OS_MODE, M_NONE, A_LINE_BASE, L_HOLD, C_NEVER, U_IDLE);
      U_SEND_LINE: w = cw(1'b0, 1'b1, OS_LINE, M_NONE, A_HOLD, L_HOLD, C_NEVER, U_IDLE);
      U_RD:        w = cw(1'b0, 1'b0, OS_ZERO, M_RD_LINE, A_HOLD, L_HOLD, C_NEVER, U_IDLE);
      U_EMIT:      w = cw(1'b0, 1'b1, OS_DATA, M_NONE, A_INC, L_HOLD, C_MORE_BYTES, U_RD);
      U_Z0:        w = cw(1'b0, 1'b1, OS_ZERO, M_NONE, A_HOLD, L_HOLD, C_NEVER, U_IDLE);
      U_Z1:        w = cw(1'b0, 1'b1, OS_ZERO_LAST, M_NONE, A_HOLD, L_ADV, C_ALWAYS, U_IDLE);
      U_KILL:      w = cw(1'b0, 1'b0, OS_ZERO, M_NONE, A_HOLD, L_KILL, C_ALWAYS, U_IDLE);
      default:     w = cw(1'b0, 1'b0, OS_ZERO, M_NONE, A_HOLD, L_HOLD, C_ALWAYS, U_IDLE);
    endcase
    return w;
  endfunction

  function automatic logic [7:0] bitrev8(input logic [7:0] b);
    logic [7:0] v;
    v = ((b & 8'hF0) >> 4) | ((b & 8'h0F) << 4);
    v = ((v & 8'hCC) >> 2) | ((v & 8'h33) << 2);
    v = ((v & 8'hAA) >> 1) | ((v & 8'h55) << 1);
    return v;
  endfunction

endpackage

// ----- hdl/lcdfs_seq.sv -----
module lcdfs_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [2:0]          in_func,
  input  logic                out_busy,
  input  lcdfs_pkg::flags_t   flags,
  output lcdfs_pkg::ctrl_word_t ctrl,
  output logic                advance
);

  lcdfs_pkg::upc_t pc_r, pc_nxt, dispatch_pc;
  logic            cond_hit;

  assign ctrl = lcdfs_pkg::ucode(pc_r);

  // A step that takes a request waits for one; a step that emits waits for a free output slot.
  assign advance = ctrl.take ? in_valid : !(ctrl.emit && out_busy);

  always_comb begin
    unique case (in_func)
      lcdfs_pkg::FN_SET_PIXEL:  dispatch_pc = lcdfs_pkg::U_PIX_RD;
      lcdfs_pkg::FN_WRITE_BYTE: dispatch_pc = lcdfs_pkg::U_WRB;
      lcdfs_pkg::FN_FILL:       dispatch_pc = lcdfs_pkg::U_FILL;
      lcdfs_pkg::FN_START:      dispatch_pc = lcdfs_pkg::U_START;
      lcdfs_pkg::FN_NEXT_LINE:  dispatch_pc = lcdfs_pkg::U_NEXT;
      default:                  dispatch_pc = lcdfs_pkg::U_IDLE;
    endcase
  end

  always_comb begin
    unique case (ctrl.cond)
      lcdfs_pkg::C_ALWAYS:     cond_hit = 1'b1;
      lcdfs_pkg::C_MORE_FILL:  cond_hit = flags.more_fill;
      lcdfs_pkg::C_MORE_BYTES: cond_hit = flags.more_bytes;
      lcdfs_pkg::C_NO_LINE:    cond_hit = flags.no_line;
      default:                 cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt = pc_r;
    if (advance) begin
      if (ctrl.cond == lcdfs_pkg::C_DISPATCH) begin
        pc_nxt = dispatch_pc;
      end else if (cond_hit) begin
        pc_nxt = ctrl.target;
      end else begin
        pc_nxt = pc_r + 4'd1;
      end
    end
  end

  // Reset enters the fill loop so the store is swept to zero before the first request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= lcdfs_pkg::U_FILL;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ----- hdl/memory_lcd_frame_streamer.sv -----
// Memory LCD frame store with line packet framer.
// Input channel (in_valid/in_ready) carries one command per request: set pixel,
// write store byte, fill store, start frame, next line. Output channel
// (out_valid/out_ready) carries packet bytes; start frame, and next line while
// a frame has lines left, each produce one packet of LINE_BYTES+4 bytes (mode
// byte, bit-reversed line number, pixel bytes, two zero bytes) with packet_last
// and frame_last flags; otherwise next line clears the frame and sends nothing.
// A microcoded sequencer runs every command; in_ready is high only in its idle
// step, so one command is worked on at a time. Set pixel does one read and one
// write of the single-port store; fill writes one store byte per cycle; start
// frame or next line needs a store read and an emit step for each pixel byte.
// After reset the sequencer sweeps the store to zero, one byte per cycle, and
// in_ready rises once the sweep is done. The output register holds its byte
// while out_ready is low and the sequencer waits on the next emit step.
module memory_lcd_frame_streamer #(
  parameter int SCREEN_WIDTH = 320,
  parameter int SCREEN_LINES = 240,
  parameter int LINE_BYTES   = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [8:0]  in_pixel_x,
  input  logic [7:0]  in_pixel_y,
  input  logic        in_pixel_white,
  input  logic [13:0] in_byte_index,
  input  logic [7:0]  in_byte_value,
  input  logic        in_fill_black,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_packet_last,
  output logic        out_frame_last
);

  localparam int STORE_BYTES = SCREEN_LINES * LINE_BYTES;
  localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int CW          = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;

  lcdfs_pkg::ctrl_word_t ctrl;
  lcdfs_pkg::flags_t     flags;
  logic                  advance;
  logic                  out_busy;

  logic [8:0]    x_r;
  logic [7:0]    y_r;
  logic          white_r;
  logic [13:0]   idx_r;
  logic [7:0]    val_r;
  logic [7:0]    fill_byte_r;
  logic [AW-1:0] addr_r;
  logic [CW-1:0] cnt_r;
  logic [7:0]    line_r;
  logic          active_r;
  logic [7:0]    rdata_r;

  logic          out_valid_r, out_packet_last_r, out_frame_last_r;
  logic [7:0]    out_byte_r;

  logic [7:0]    store [STORE_BYTES];

  logic          pix_ok, idx_ok, last_line;
  logic [AW-1:0] pix_addr, line_base, mem_addr;
  logic [7:0]    pix_mask, pix_byte, mem_wdata, emit_byte;
  logic          mem_we, mem_re;

  lcdfs_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .out_busy (out_busy),
    .flags    (flags),
    .ctrl     (ctrl),
    .advance  (advance)
  );

  assign in_ready = ctrl.take;
  assign out_busy = out_valid_r && !out_ready;

  assign pix_ok = (32'(x_r) < SCREEN_WIDTH) && (32'(y_r) < SCREEN_LINES) &&
                  (32'(x_r[8:3]) < LINE_BYTES);
  assign idx_ok = 32'(idx_r) < STORE_BYTES;
  assign pix_addr  = AW'(32'(y_r) * LINE_BYTES + 32'(x_r[8:3]));
  assign line_base = AW'(32'(line_r) * LINE_BYTES);
  assign pix_mask  = 8'h80 >> x_r[2:0];
  assign pix_byte  = white_r ? (rdata_r | pix_mask) : (rdata_r & ~pix_mask);
  assign last_line = 32'(line_r) >= SCREEN_LINES - 1;

  assign flags.more_fill  = addr_r != AW'(STORE_BYTES - 1);
  assign flags.more_bytes = cnt_r != CW'(LINE_BYTES - 1);
  assign flags.no_line    = !active_r || (32'(line_r) >= SCREEN_LINES);

  always_comb begin
    mem_addr  = addr_r;
    mem_wdata = fill_byte_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    case (ctrl.mem)
      lcdfs_pkg::M_RD_PIX: begin
        mem_addr = pix_addr;
        mem_re   = advance;
      end
      lcdfs_pkg::M_WR_PIX: begin
        mem_addr  = pix_addr;
        mem_wdata = pix_byte;
        mem_we    = advance && pix_ok;
      end
      lcdfs_pkg::M_WR_BYTE: begin
        mem_addr  = AW'(idx_r);
        mem_wdata = val_r;
        mem_we    = advance && idx_ok;
      end
      lcdfs_pkg::M_WR_FILL: begin
        mem_we = advance;
      end
      lcdfs_pkg::M_RD_LINE: begin
        mem_re = advance;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= store[mem_addr];
    end
  end

  always_comb begin
    unique case (ctrl.osel)
      lcdfs_pkg::OS_MODE: emit_byte = lcdfs_pkg::PKT_LEAD;
      lcdfs_pkg::OS_LINE: emit_byte = lcdfs_pkg::bitrev8(line_r + 8'd1);
      lcdfs_pkg::OS_DATA: emit_byte = rdata_r;
      default:            emit_byte = 8'h00;
    endcase
  end

  // Latched request fields; no reset needed.
  always_ff @(posedge clk) begin
    if (ctrl.take && in_valid) begin
      x_r     <= in_pixel_x;
      y_r     <= in_pixel_y;
      white_r <= in_pixel_white;
      idx_r   <= in_byte_index;
      val_r   <= in_byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_byte_r <= 8'h00;
      addr_r      <= '0;
      cnt_r       <= '0;
      line_r      <= 8'd0;
      active_r    <= 1'b0;
    end else if (advance) begin
      if (ctrl.take) begin
        addr_r <= '0;
        if (in_func == lcdfs_pkg::FN_FILL) begin
          fill_byte_r <= in_fill_black ? 8'h00 : 8'hFF;
        end
      end
      case (ctrl.aop)
        lcdfs_pkg::A_LINE_BASE: begin
          addr_r <= line_base;
          cnt_r  <= '0;
        end
        lcdfs_pkg::A_INC: begin
          addr_r <= addr_r + AW'(1);
          cnt_r  <= cnt_r + CW'(1);
        end
        default: begin
        end
      endcase
      case (ctrl.lop)
        lcdfs_pkg::L_START: begin
          line_r   <= 8'd0;
          active_r <= 1'b1;
        end
        lcdfs_pkg::L_ADV: begin
          line_r <= line_r + 8'd1;
          if (last_line) begin
            active_r <= 1'b0;
          end
        end
        lcdfs_pkg::L_KILL: begin
          active_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ctrl.emit) begin
      out_byte_r        <= emit_byte;
      out_packet_last_r <= ctrl.osel == lcdfs_pkg::OS_ZERO_LAST;
      out_frame_last_r  <= (ctrl.osel == lcdfs_pkg::OS_ZERO_LAST) && last_line;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_packet_last = out_packet_last_r;
  assign out_frame_last  = out_frame_last_r;

endmodule

// ----- hdl/lcdfs_checker.sv -----
module lcdfs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_packet_last,
  input logic       out_frame_last
);

  // The store is swept clear after reset before any request is taken.
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("request taken right after reset");

  a_frame_end_is_packet_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_packet_last)
    else $error("frame end flagged off a packet end");

  a_packet_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_last |-> out_byte == 8'h00)
    else $error("packet tail byte is not zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
    $stable(out_packet_last) && $stable(out_frame_last))
    else $error("stalled output changed");

endmodule

bind memory_lcd_frame_streamer lcdfs_checker u_lcdfs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .out_packet_last (out_packet_last),
  .out_frame_last  (out_frame_last)
);
